### design/point_to_polyline_cylinder_test_defines.svh
// Assertion macros for the point-to-polyline cylinder test.
// Used by the top level only; no other dependencies.
`ifndef POINT_TO_POLYLINE_CYLINDER_TEST_DEFINES_SVH
`define POINT_TO_POLYLINE_CYLINDER_TEST_DEFINES_SVH

// Assert that an implication holds on every clock edge outside reset.
`define P2P_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert that an implication holds with the consequent checked in the next cycle.
`define P2P_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/p2pcyl_pkg.sv
// Package for the point-to-polyline cylinder test: payload types, mode codes.
// No dependencies.
package p2pcyl_pkg;

	localparam int CoordBits = 20;
	localparam int RadiusBits = 16;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_QUERY  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]                  mode;
		logic signed [CoordBits-1:0] pos_x;
		logic signed [CoordBits-1:0] pos_y;
		logic signed [CoordBits-1:0] pos_z;
	} cmd_t;

	typedef struct packed {
		logic near_track;
		logic segment_in_range;
	} result_t;

	// Segment handed from cell to cell along the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

### design/p2pcyl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module p2pcyl_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### design/p2pcyl_cell.sv
// One cell of the segment pipeline: a register stage that computes part of
// the cylinder test and hands its results to the next stage. Uses p2pcyl_pkg.
module p2pcyl_cell #(
	parameter int IW = 21,
	parameter int OW = 21
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  p2pcyl_pkg::tag_t       tag_in,
	input  logic signed [IW-1:0]   a_in,
	input  logic signed [IW-1:0]   b_in,
	output p2pcyl_pkg::tag_t       tag_out,
	output logic signed [OW-1:0]   prod_out
);
	// Each cell multiplies its operand pair; stage register follows.
	logic signed [2*IW-1:0] prod;

	assign prod = (2*IW)'(a_in) * (2*IW)'(b_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_out <= OW'(prod);
	end
endmodule

### design/point_to_polyline_cylinder_test.sv
// Point-to-polyline cylinder test, top level. Uses p2pcyl_pkg, p2pcyl_ram, p2pcyl_cell.
// Append, clear and the unused code are accepted with no result and leave busy low. A query
// over N stored vertices (N at most MAX_VERTICES) reads one vertex per cycle, then runs down a
// drain count before its result strobe; an empty track goes straight to the drain.
// A query holds busy high until its strobe cycle; the strobe cannot be stalled.
// Reset zeroes the vertex count and sets the radius to 102; stored vertices stay unset.
`include "point_to_polyline_cylinder_test_defines.svh"

module point_to_polyline_cylinder_test #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  p2pcyl_pkg::cmd_t      cmd,
	output logic                  done,
	output p2pcyl_pkg::result_t   result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);
	// The coordinate width is fixed by the payload struct in the package.
	localparam int COORD_BITS = p2pcyl_pkg::CoordBits;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_BITS + 1;   // difference width
	localparam int SW = 2 * DW + 2;       // sum of three squares / dot products
	localparam int HW = DW;               // limb width of the quartic products
	localparam int OPW = 2 * HW;          // quartic operand width
	localparam int QW = 2 * OPW + 2;      // quartic terms
	localparam int RW = 32;               // radius squared

	// Controller state.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam int DRAIN_CYCLES = 8;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [3:0]    drain_q;
	logic [15:0]   radius_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic          near_q, inrange_q;

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	// The radius may only change while no query is walking the track.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd102;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	// Vertex memories, one per axis. An append writes at the current count.
	logic              we;
	logic [AW-1:0]     raddr;
	logic [COORD_BITS-1:0] rx, ry, rz;
	assign we = accept && cmd.mode == p2pcyl_pkg::MODE_APPEND && count_q < CW'(MAX_VERTICES);
	assign raddr = rd_idx_q[AW-1:0];

	p2pcyl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_x (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(COORD_BITS'(cmd.pos_x)),
		.raddr(raddr), .rdata(rx));
	p2pcyl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_y (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(COORD_BITS'(cmd.pos_y)),
		.raddr(raddr), .rdata(ry));
	p2pcyl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_z (
		.clk(clk), .we(we), .waddr(count_q[AW-1:0]), .wdata(COORD_BITS'(cmd.pos_z)),
		.raddr(raddr), .rdata(rz));

	// Sequencer: reads vertex 0..count-1 in order, one per cycle. The drain
	// count is loaded when the query is taken and runs down once the reads end,
	// which leaves room for the last segment to pass every stage below.
	p2pcyl_pkg::tag_t rd_tag_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			drain_q   <= '0;
			rd_tag_s1 <= '0;
		end else begin
			rd_tag_s1.valid <= (state_q == ST_RUN);
			rd_tag_s1.last  <= (state_q == ST_RUN) && (rd_idx_q == count_q - 1'b1);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.mode)
							p2pcyl_pkg::MODE_APPEND: begin
								// An append to a full track is dropped.
								if (count_q < CW'(MAX_VERTICES)) begin
									count_q <= count_q + 1'b1;
								end
							end
							p2pcyl_pkg::MODE_CLEAR: count_q <= '0;
							p2pcyl_pkg::MODE_QUERY: begin
								rd_idx_q <= '0;
								state_q  <= (count_q == '0) ? ST_DRAIN : ST_RUN;
								drain_q  <= 4'(DRAIN_CYCLES);
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (rd_idx_q == count_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 4'd0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.mode == p2pcyl_pkg::MODE_QUERY) begin
			px_q <= COORD_BITS'(cmd.pos_x);
			py_q <= COORD_BITS'(cmd.pos_y);
			pz_q <= COORD_BITS'(cmd.pos_z);
		end
	end

	// Stage 2: vertex arrives from memory; pair it with the previous vertex.
	p2pcyl_pkg::tag_t tag_s2;
	logic first_s2;
	logic signed [COORD_BITS-1:0] prevx_q, prevy_q, prevz_q;
	logic signed [DW-1:0] dx_s2, dy_s2, dz_s2, qx_s2, qy_s2, qz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			first_s2 <= 1'b1;
		end else begin
			// The first vertex of a walk only primes the previous-vertex register.
			tag_s2.valid <= rd_tag_s1.valid && !first_s2;
			tag_s2.last  <= rd_tag_s1.last;
			if (rd_tag_s1.valid) begin
				first_s2 <= rd_tag_s1.last;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (rd_tag_s1.valid) begin
			prevx_q <= rx;
			prevy_q <= ry;
			prevz_q <= rz;
		end
		dx_s2 <= DW'(signed'(rx)) - DW'(prevx_q);
		dy_s2 <= DW'(signed'(ry)) - DW'(prevy_q);
		dz_s2 <= DW'(signed'(rz)) - DW'(prevz_q);
		qx_s2 <= DW'(px_q) - DW'(prevx_q);
		qy_s2 <= DW'(py_q) - DW'(prevy_q);
		qz_s2 <= DW'(pz_q) - DW'(prevz_q);
	end

	// Stage 3: nine products in a row of cells.
	p2pcyl_pkg::tag_t tag_c [9];
	logic signed [2*DW-1:0] pr [9];
	logic signed [DW-1:0] ca [9];
	logic signed [DW-1:0] cb [9];
	assign ca = '{dx_s2, dy_s2, dz_s2, qx_s2, qy_s2, qz_s2, qx_s2, qy_s2, qz_s2};
	assign cb = '{dx_s2, dy_s2, dz_s2, dx_s2, dy_s2, dz_s2, qx_s2, qy_s2, qz_s2};
	for (genvar g = 0; g < 9; g++) begin : g_prod
		p2pcyl_cell #(.IW(DW), .OW(2*DW)) u_cell (
			.clk(clk), .arst_n(arst_n), .tag_in(tag_s2),
			.a_in(ca[g]), .b_in(cb[g]), .tag_out(tag_c[g]), .prod_out(pr[g]));
	end

	// Stage 4: sums of three.
	p2pcyl_pkg::tag_t tag_s4;
	logic signed [SW-1:0] ab2_s4, dot_s4, pp_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tag_s4 <= '0;
		else tag_s4 <= tag_c[0];
	end
	always_ff @(posedge clk) begin
		ab2_s4 <= SW'(pr[0]) + SW'(pr[1]) + SW'(pr[2]);
		dot_s4 <= SW'(pr[3]) + SW'(pr[4]) + SW'(pr[5]);
		pp_s4  <= SW'(pr[6]) + SW'(pr[7]) + SW'(pr[8]);
	end

	// Stage 5: projection range check and the partial products of the quartics.
	// When a segment counts, every quartic operand is nonnegative and below
	// 2^OPW, so each one is split into two HW-bit limbs and the products are
	// formed limb by limb, four small cells per quartic.
	p2pcyl_pkg::tag_t tag_s5;
	logic cnt_s5;
	logic [RW-1:0] r2_q;
	always_ff @(posedge clk) begin
		r2_q <= RW'(radius_q) * RW'(radius_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
			cnt_s5 <= 1'b0;
		end else begin
			tag_s5 <= tag_s4;
			cnt_s5 <= tag_s4.valid && ab2_s4 != '0 && !dot_s4[SW-1] && dot_s4 <= ab2_s4;
		end
	end

	// Quartic 0 is pp*ab2, quartic 1 is dot*dot and quartic 2 is r^2*ab2.
	logic [OPW-1:0] qa [3];
	logic [OPW-1:0] qb [3];
	assign qa = '{pp_s4[OPW-1:0], dot_s4[OPW-1:0], OPW'(r2_q)};
	assign qb = '{ab2_s4[OPW-1:0], dot_s4[OPW-1:0], ab2_s4[OPW-1:0]};

	p2pcyl_pkg::tag_t tag_m [12];
	logic signed [HW:0] ma [12];
	logic signed [HW:0] mb [12];
	logic signed [2*HW+1:0] mp [12];
	for (genvar k = 0; k < 3; k++) begin : g_quart
		// Limb pairs in the order high*high, high*low, low*high, low*low.
		assign ma[4*k]   = {1'b0, qa[k][OPW-1:HW]};
		assign mb[4*k]   = {1'b0, qb[k][OPW-1:HW]};
		assign ma[4*k+1] = {1'b0, qa[k][OPW-1:HW]};
		assign mb[4*k+1] = {1'b0, qb[k][HW-1:0]};
		assign ma[4*k+2] = {1'b0, qa[k][HW-1:0]};
		assign mb[4*k+2] = {1'b0, qb[k][OPW-1:HW]};
		assign ma[4*k+3] = {1'b0, qa[k][HW-1:0]};
		assign mb[4*k+3] = {1'b0, qb[k][HW-1:0]};
	end
	for (genvar g = 0; g < 12; g++) begin : g_limb
		p2pcyl_cell #(.IW(HW + 1), .OW(2*HW + 2)) u_cell (
			.clk(clk), .arst_n(arst_n), .tag_in(tag_s4),
			.a_in(ma[g]), .b_in(mb[g]), .tag_out(tag_m[g]), .prod_out(mp[g]));
	end

	// Stage 6: the limb products are shifted into place and summed.
	logic [QW-1:0] quart_s6 [3];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			quart_s6[k] <= (QW'(mp[4*k][2*HW-1:0]) << OPW)
				+ ((QW'(mp[4*k+1][2*HW-1:0]) + QW'(mp[4*k+2][2*HW-1:0])) << HW)
				+ QW'(mp[4*k+3][2*HW-1:0]);
		end
	end

	// Stage 7: strict compare |AP|^2*|AB|^2 < (AP.AB)^2 + r^2*|AB|^2.
	logic near_s7;
	always_ff @(posedge clk) begin
		near_s7 <= quart_s6[0] < quart_s6[1] + quart_s6[2];
	end

	// Accumulate over the walk. The flags are cleared when a query is taken and
	// the result is strobed when the drain ends, after all segments have landed.
	logic cnt_s6, cnt_s7, valid_s6, valid_s7, last_s6, last_s7, fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s6 <= 1'b0; cnt_s7 <= 1'b0;
			valid_s6 <= 1'b0; valid_s7 <= 1'b0;
			last_s6 <= 1'b0; last_s7 <= 1'b0;
			near_q <= 1'b0; inrange_q <= 1'b0; fin_q <= 1'b0;
			done <= 1'b0;
		end else begin
			cnt_s6   <= cnt_s5 && tag_m[0].valid;
			cnt_s7   <= cnt_s6;
			valid_s6 <= tag_s5.valid;
			valid_s7 <= valid_s6;
			last_s6  <= tag_s5.last;
			last_s7  <= last_s6;
			if (accept && cmd.mode == p2pcyl_pkg::MODE_QUERY) begin
				near_q <= 1'b0; inrange_q <= 1'b0;
			end else begin
				if (cnt_s7) begin
					inrange_q <= 1'b1;
					if (near_s7) near_q <= 1'b1;
				end
			end
			done  <= (state_q == ST_DRAIN && drain_q == 4'd0);
			fin_q <= valid_s7 && last_s7;
		end
	end
	assign result.near_track = near_q;
	assign result.segment_in_range = inrange_q;

	// The strobe follows the end of the drain, a near answer always comes with a
	// counting segment, the count never passes capacity, and the last segment of a
	// walk does not reach the end of the pipeline while vertices are still being read.
	`P2P_ASSERT_NEXT(a_done_after_drain, state_q == ST_DRAIN && drain_q == 4'd0, done,
		"missing done")
	`P2P_ASSERT_IMPL(a_near_implies_range, done,
		!result.near_track || result.segment_in_range, "near without range")
	`P2P_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(MAX_VERTICES), "count overflow")
	`P2P_ASSERT_IMPL(a_no_start_busy, state_q == ST_RUN, busy && !fin_q, "walk state")
endmodule

### test/tb_point_to_polyline_cylinder_test.sv
// Self-checking testbench for the point-to-polyline cylinder test block.
// Depends on p2pcyl_pkg and the point_to_polyline_cylinder_test top level.
`timescale 1ns / 1ps

module tb_point_to_polyline_cylinder_test;

	localparam int MaxVerts = 1024;
	localparam int QueryDrain = MaxVerts + 40;
	localparam int CoordBits = p2pcyl_pkg::CoordBits;
	// The one mode code that the block ignores.
	localparam logic [1:0] ModeUnused = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	p2pcyl_pkg::cmd_t cmd = '0;
	logic done;
	p2pcyl_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	// Predictor copy of the track and the radius.
	logic signed [CoordBits-1:0] track_x [MaxVerts];
	logic signed [CoordBits-1:0] track_y [MaxVerts];
	logic signed [CoordBits-1:0] track_z [MaxVerts];
	int unsigned track_len;
	logic [15:0] radius;

	// Proximity answers still owed by the block, oldest first.
	p2pcyl_pkg::result_t pending_answers [$];
	int unsigned mismatches = 0;
	int unsigned answers_seen = 0;
	int unsigned near_seen = 0;
	int unsigned items_sent = 0;

	always #5 clk = ~clk;

	point_to_polyline_cylinder_test uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Exact proximity test of point p against the predictor's track. The widest
	// product is below 2^84 in magnitude, so 192 signed bits cannot overflow.
	function automatic p2pcyl_pkg::result_t proximity_answer(input p2pcyl_pkg::cmd_t c);
		logic signed [191:0] dx, dy, dz, qx, qy, qz, ab2, dot, pp, r2;
		p2pcyl_pkg::result_t r;
		r = '0;
		r2 = $signed({176'd0, radius}) * $signed({176'd0, radius});
		for (int j = 0; j + 1 < track_len; j++) begin
			dx = 192'(track_x[j+1]) - 192'(track_x[j]);
			dy = 192'(track_y[j+1]) - 192'(track_y[j]);
			dz = 192'(track_z[j+1]) - 192'(track_z[j]);
			qx = 192'(c.pos_x) - 192'(track_x[j]);
			qy = 192'(c.pos_y) - 192'(track_y[j]);
			qz = 192'(c.pos_z) - 192'(track_z[j]);
			ab2 = dx*dx + dy*dy + dz*dz;
			dot = qx*dx + qy*dy + qz*dz;
			if (ab2 == 0 || dot < 0 || dot > ab2)
				continue;
			r.segment_in_range = 1'b1;
			pp = qx*qx + qy*qy + qz*qz;
			if (pp*ab2 < dot*dot + r2*ab2)
				r.near_track = 1'b1;
		end
		return r;
	endfunction

	// Updates the predictor for one accepted command.
	task automatic track_update(input p2pcyl_pkg::cmd_t c);
		if (c.mode == p2pcyl_pkg::MODE_APPEND) begin
			if (track_len < MaxVerts) begin
				track_x[track_len] = c.pos_x;
				track_y[track_len] = c.pos_y;
				track_z[track_len] = c.pos_z;
				track_len++;
			end
		end else if (c.mode == p2pcyl_pkg::MODE_CLEAR) begin
			track_len = 0;
		end else if (c.mode == p2pcyl_pkg::MODE_QUERY) begin
			pending_answers = {pending_answers, proximity_answer(c)};
		end
	endtask

	// Sends one command; start stays high until the block takes it, and is left
	// high so that the next command of a burst can follow without a gap.
	task automatic send_command(input p2pcyl_pkg::cmd_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_update(c);
		items_sent++;
	endtask

	// Drops start and waits for the next clock edge.
	task automatic stop_sending();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Random gap that sometimes falls between bursts.
	int unsigned burst_left = 0;
	task automatic sender_gap();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
		end
		burst_left--;
	endtask

	function automatic p2pcyl_pkg::cmd_t make_cmd(input logic [1:0] m, input int x,
	                                              input int y, input int z);
		p2pcyl_pkg::cmd_t c;
		c.mode = m;
		c.pos_x = x[CoordBits-1:0];
		c.pos_y = y[CoordBits-1:0];
		c.pos_z = z[CoordBits-1:0];
		return c;
	endfunction

	// Waits until every answer has arrived, then past the block's longest job.
	task automatic wait_idle();
		stop_sending();
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (QueryDrain)
			@(posedge clk);
	endtask

	// Holds off until every answer is in.
	task automatic wait_answers();
		stop_sending();
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_radius(input logic [15:0] r);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		radius = r;
		cfg_valid <= 1'b0;
	endtask

	// A point near a base that stays clear of overflow-free but varied values.
	function automatic int jitter(input int base, input int span);
		return base + $signed($urandom_range(0, 2*span)) - span;
	endfunction

	// Directed: extremes, every mode, the unused code, short tracks, zero-length
	// segments, endpoints, and points exactly on the radius.
	task automatic test_directed();
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 0, 0, 0));       // empty track
		send_command(make_cmd(p2pcyl_pkg::MODE_APPEND, 0, 0, 0));
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 0, 0, 0));       // one vertex only
		send_command(make_cmd(p2pcyl_pkg::MODE_APPEND, 0, 0, 0));      // zero-length segment
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 0, 0, 0));
		send_command(make_cmd(p2pcyl_pkg::MODE_APPEND, 1000, 0, 0));
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 500, 101, 0));   // inside radius
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 500, 102, 0));   // exactly on radius
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 0, 0, 0));       // start endpoint
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 1000, 50, 0));   // end endpoint
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 1001, 0, 0));    // just past the end
		send_command(make_cmd(ModeUnused, 7, 7, 7));                    // unused code
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, -1, 0, 0));      // just before start
		send_command(make_cmd(p2pcyl_pkg::MODE_CLEAR, 0, 0, 0));
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 500, 0, 0));     // cleared track
		send_command(make_cmd(p2pcyl_pkg::MODE_APPEND, -524288, -524288, -524288));
		send_command(make_cmd(p2pcyl_pkg::MODE_APPEND, 524287, 524287, 524287));
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 524287, -524288, 524287));
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, 0, 0, 0));
		send_command(make_cmd(p2pcyl_pkg::MODE_QUERY, -524288, -524288, -524288));
		send_command(make_cmd(p2pcyl_pkg::MODE_CLEAR, -1, -1, -1));
	endtask

	// Mostly realistic tracks with points scattered near them; some noise.
	task automatic test_random_tracks(input int unsigned n_items);
		int cx, cy, cz, span;
		p2pcyl_pkg::cmd_t c;
		cx = 0; cy = 0; cz = 0;
		span = 400;
		for (int unsigned i = 0; i < n_items; i++) begin
			sender_gap();
			case ($urandom_range(0, 19))
				0: c = make_cmd(p2pcyl_pkg::MODE_CLEAR, $urandom, $urandom, $urandom);
				1: c = make_cmd(ModeUnused, $urandom, $urandom, $urandom);
				2, 3: c = make_cmd(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
				4, 5, 6, 7, 8, 9: begin
					cx = jitter(cx, 300); cy = jitter(cy, 300); cz = jitter(cz, 300);
					if ($urandom_range(0, 9) == 0) begin
						cx = 0; cy = 0; cz = 0;
					end
					c = make_cmd(p2pcyl_pkg::MODE_APPEND, cx, cy, cz);
				end
				default: begin
					span = ($urandom_range(0, 1) != 0) ? 150 : 600;
					c = make_cmd(p2pcyl_pkg::MODE_QUERY, jitter(cx, span), jitter(cy, span),
					             jitter(cz, span));
				end
			endcase
			send_command(c);
		end
	endtask

	// Checks each answer against the oldest prediction as it is strobed out.
	always @(posedge clk) begin
		if (arst_n && done) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				report_mismatch("answer with no query outstanding");
			end else begin
				p2pcyl_pkg::result_t want;
				want = pending_answers.pop_front();
				if (result.near_track !== want.near_track)
					report_mismatch($sformatf("near_track %b, expected %b",
					                 result.near_track, want.near_track));
				if (result.segment_in_range !== want.segment_in_range)
					report_mismatch($sformatf("segment_in_range %b, expected %b",
					                 result.segment_in_range, want.segment_in_range));
				if (want.near_track)
					near_seen++;
			end
		end
	end

	// Run limit: far past a slow correct run of every phase.
	initial begin
		#(64'd20_000_000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		track_len = 0;
		radius = 16'd102;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_idle();
		write_radius(16'd0);
		test_directed();
		wait_idle();
		write_radius(16'hFFFF);
		test_directed();
		test_random_tracks(40);
		wait_idle();
		write_radius(16'd200);
		test_random_tracks(100);
		wait_answers();
		test_random_tracks(100);
		wait_idle();
		write_radius(16'd102);
		test_random_tracks(100);
		wait_idle();

		$display("Ran %0d commands over several radii; %0d answers, %0d near the track.",
		         items_sent, answers_seen, near_seen);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/p2pcyl_pkg.sv
design/p2pcyl_ram.sv
design/p2pcyl_cell.sv
design/point_to_polyline_cylinder_test.sv
test/tb_point_to_polyline_cylinder_test.sv
